### rtl/fru_asm_pkg.sv
// shared types and constants for the fru activation state machine
// no dependencies; imported by the top level, the checkers and the testbench
package fru_asm_pkg;

  // reset value of the activation timeout register
  localparam logic [31:0] TIMEOUT_RESET = 32'd6000;

  // reported state codes
  localparam logic [2:0] CODE_INACTIVE     = 3'd0;
  localparam logic [2:0] CODE_POWERED      = 3'd1;
  localparam logic [2:0] CODE_ACTIVATING   = 3'd2;
  localparam logic [2:0] CODE_ACTIVE       = 3'd3;
  localparam logic [2:0] CODE_DEACTIVATING = 3'd4;

  // power rail command codes
  localparam logic [1:0] CMD_NONE = 2'd0;
  localparam logic [1:0] CMD_ON   = 2'd1;
  localparam logic [1:0] CMD_OFF  = 2'd2;

  // fru state, one-hot
  typedef enum logic [4:0] {
    ST_INACTIVE     = 5'b00001,
    ST_POWERED      = 5'b00010,
    ST_ACTIVATING   = 5'b00100,
    ST_ACTIVE       = 5'b01000,
    ST_DEACTIVATING = 5'b10000
  } fru_state_t;

  // one result item as held in the output register
  typedef struct packed {
    logic [2:0] state_code;
    logic       cpu_healthy;
    logic       other_alarm;
    logic       alarm_raised;
    logic [1:0] payload_cmd;
    logic [1:0] main_power_cmd;
    logic [1:0] mgmt_power_cmd;
    logic       clear_activation;
  } result_t;

  // map the one-hot state to its reported code
  function automatic logic [2:0] state_code_f(fru_state_t st);
    logic [2:0] code;
    case (st)
      ST_INACTIVE:     code = CODE_INACTIVE;
      ST_POWERED:      code = CODE_POWERED;
      ST_ACTIVATING:   code = CODE_ACTIVATING;
      ST_ACTIVE:       code = CODE_ACTIVE;
      ST_DEACTIVATING: code = CODE_DEACTIVATING;
      default:         code = CODE_INACTIVE;
    endcase
    return code;
  endfunction

endpackage

### rtl/fru_asm_if.sv
// valid/ready channel interfaces: poll input, result output, config write
// depends on nothing but plain logic types
interface fru_asm_in_if;
  logic        valid;
  logic        ready;
  logic        activation_enable;
  logic        heartbeat;
  logic [31:0] now_cycle;
  logic        insertion;

  modport source (output valid, output activation_enable, output heartbeat,
                  output now_cycle, output insertion, input ready);
  modport sink   (input valid, input activation_enable, input heartbeat,
                  input now_cycle, input insertion, output ready);
endinterface

interface fru_asm_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] state_code;
  logic       cpu_healthy;
  logic       other_alarm;
  logic       alarm_raised;
  logic [1:0] payload_cmd;
  logic [1:0] main_power_cmd;
  logic [1:0] mgmt_power_cmd;
  logic       clear_activation;

  modport source (output valid, output state_code, output cpu_healthy,
                  output other_alarm, output alarm_raised, output payload_cmd,
                  output main_power_cmd, output mgmt_power_cmd,
                  output clear_activation, input ready);
  modport sink   (input valid, input state_code, input cpu_healthy,
                  input other_alarm, input alarm_raised, input payload_cmd,
                  input main_power_cmd, input mgmt_power_cmd,
                  input clear_activation, output ready);
endinterface

interface fru_asm_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/fru_activation_state_machine_top.sv
// fru hot-swap activation state machine, top level
// depends on fru_asm_pkg and the channel interfaces in fru_asm_if.sv
//
// usage:
//   in_ch  : one management poll per transfer (enable, heartbeat,
//            cycle count, insertion flag)
//   out_ch : one result per poll (state, health, alarm, raise pulse,
//            rail commands, clear-activation request)
//   cfg_ch : write of the activation timeout; always ready, to be used
//            only while no poll is in flight
//   latency: the result of a poll is valid the cycle after its transfer
//   rate   : one poll per cycle; the state update is a single compare of
//            a 32-bit wrapping difference against the timeout, done in the
//            cycle the poll is taken
//   stall  : the single output register holds its result while out_ch is
//            stalled; in_ch stays ready as long as that register is empty
//            or is emptied in the same cycle
//   reset  : rst_n (synchronous, active low) returns to the inactive state,
//            clears start, health and alarm, reloads the timeout with 6000
//            and empties the output register
module fru_activation_state_machine_top
  import fru_asm_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  fru_asm_in_if.sink    in_ch,
  fru_asm_out_if.source out_ch,
  fru_asm_cfg_if.sink   cfg_ch
);

  fru_state_t  state_r, state_nxt;
  logic [31:0] start_r, start_nxt;
  logic        health_r, health_nxt;
  logic        alarm_r, alarm_nxt;
  logic [31:0] timeout_r;
  logic        out_valid_r;
  result_t     res_r, res_nxt;
  logic        in_fire;
  logic [31:0] elapsed;
  logic        timed_out;

  // handshake
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // wrapping elapsed time since activation start
  assign elapsed   = in_ch.now_cycle - start_r;
  assign timed_out = elapsed > timeout_r;

  // next state and commands for one poll
  always_comb begin
    state_nxt  = state_r;
    start_nxt  = start_r;
    health_nxt = health_r;
    alarm_nxt  = alarm_r;
    res_nxt    = '0;
    res_nxt.payload_cmd    = CMD_NONE;
    res_nxt.main_power_cmd = CMD_NONE;
    res_nxt.mgmt_power_cmd = CMD_NONE;
    case (state_r)
      ST_INACTIVE: begin
        health_nxt = 1'b0;
        alarm_nxt  = 1'b1;
        res_nxt.alarm_raised     = 1'b1;
        res_nxt.clear_activation = 1'b1;
        res_nxt.payload_cmd      = CMD_OFF;
        res_nxt.main_power_cmd   = CMD_OFF;
        res_nxt.mgmt_power_cmd   = CMD_OFF;
        if (in_ch.insertion) begin
          state_nxt = ST_POWERED;
        end
      end
      ST_POWERED: begin
        if (!in_ch.activation_enable) begin
          health_nxt = 1'b0;
          alarm_nxt  = 1'b1;
          res_nxt.alarm_raised   = 1'b1;
          res_nxt.main_power_cmd = CMD_ON;
          res_nxt.payload_cmd    = CMD_OFF;
        end else begin
          res_nxt.mgmt_power_cmd = CMD_ON;
          res_nxt.main_power_cmd = CMD_ON;
          res_nxt.payload_cmd    = CMD_ON;
          start_nxt = in_ch.now_cycle;
          state_nxt = ST_ACTIVATING;
        end
      end
      ST_ACTIVATING: begin
        if (!in_ch.activation_enable) begin
          res_nxt.payload_cmd = CMD_OFF;
          state_nxt = ST_DEACTIVATING;
        end else begin
          if (in_ch.heartbeat) begin
            health_nxt = 1'b1;
            alarm_nxt  = 1'b0;
            state_nxt  = ST_ACTIVE;
          end
          // timeout overrides the heartbeat for the status bits
          if (timed_out) begin
            health_nxt = 1'b0;
            alarm_nxt  = 1'b1;
            res_nxt.alarm_raised = 1'b1;
          end
        end
      end
      ST_ACTIVE: begin
        if (!in_ch.activation_enable) begin
          res_nxt.payload_cmd = CMD_OFF;
          state_nxt = ST_DEACTIVATING;
        end else begin
          health_nxt = 1'b1;
          alarm_nxt  = 1'b0;
        end
      end
      ST_DEACTIVATING: begin
        health_nxt = 1'b0;
        alarm_nxt  = 1'b1;
        res_nxt.alarm_raised = 1'b1;
        if (!in_ch.activation_enable) begin
          state_nxt = ST_POWERED;
        end else begin
          start_nxt = in_ch.now_cycle;
          state_nxt = ST_ACTIVATING;
        end
      end
      default: begin
        state_nxt = state_r;
      end
    endcase
    res_nxt.state_code  = state_code_f(state_nxt);
    res_nxt.cpu_healthy = health_nxt;
    res_nxt.other_alarm = alarm_nxt;
  end

  // control state and timeout register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INACTIVE;
      start_r     <= '0;
      health_r    <= 1'b0;
      alarm_r     <= 1'b0;
      timeout_r   <= TIMEOUT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        timeout_r <= cfg_ch.data;
      end
      if (in_fire) begin
        state_r     <= state_nxt;
        start_r     <= start_nxt;
        health_r    <= health_nxt;
        alarm_r     <= alarm_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  // output channel
  assign out_ch.valid            = out_valid_r;
  assign out_ch.state_code       = res_r.state_code;
  assign out_ch.cpu_healthy      = res_r.cpu_healthy;
  assign out_ch.other_alarm      = res_r.other_alarm;
  assign out_ch.alarm_raised     = res_r.alarm_raised;
  assign out_ch.payload_cmd      = res_r.payload_cmd;
  assign out_ch.main_power_cmd   = res_r.main_power_cmd;
  assign out_ch.mgmt_power_cmd   = res_r.mgmt_power_cmd;
  assign out_ch.clear_activation = res_r.clear_activation;

endmodule

### rtl/fru_asm_checker.sv
// port-level checks for the fru activation state machine, with its bind
// depends on fru_asm_pkg and fru_activation_state_machine_top
module fru_asm_checker
  import fru_asm_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] state_code,
  input logic       cpu_healthy,
  input logic       other_alarm,
  input logic       alarm_raised,
  input logic [1:0] payload_cmd,
  input logic [1:0] main_power_cmd,
  input logic [1:0] mgmt_power_cmd,
  input logic       clear_activation
);

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(state_code)
      && $stable(alarm_raised) && $stable(payload_cmd))
    else $error("stalled result changed");

  // only the five defined states are reported
  a_state_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_code <= CODE_DEACTIVATING)
    else $error("undefined state code reported");

  // a raise pulse leaves the alarm set and health cleared
  a_raise_bits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && alarm_raised |-> other_alarm && !cpu_healthy)
    else $error("alarm raised without alarm bit set");

  // clear-activation comes with all rails off
  a_clear_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && clear_activation |-> payload_cmd == CMD_OFF
      && main_power_cmd == CMD_OFF && mgmt_power_cmd == CMD_OFF)
    else $error("clear request without all rails off");

endmodule

bind fru_activation_state_machine_top fru_asm_checker u_fru_asm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .state_code       (out_ch.state_code),
  .cpu_healthy      (out_ch.cpu_healthy),
  .other_alarm      (out_ch.other_alarm),
  .alarm_raised     (out_ch.alarm_raised),
  .payload_cmd      (out_ch.payload_cmd),
  .main_power_cmd   (out_ch.main_power_cmd),
  .mgmt_power_cmd   (out_ch.mgmt_power_cmd),
  .clear_activation (out_ch.clear_activation)
);

### tb/sv/fru_asm_poll_checker.sv
`timescale 1ns / 100ps
// watches the poll, result and timeout-write channels of the fru state machine
// depends on fru_asm_pkg and the channel interfaces in fru_asm_if.sv
module fru_asm_poll_checker
  import fru_asm_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  fru_asm_in_if  in_ch,
  fru_asm_out_if out_ch,
  fru_asm_cfg_if cfg_ch,
  output int     pending,
  output int     fail_count
);

  // own copy of the block state and timeout register
  logic [31:0] timeout_q;
  logic [2:0]  fru_code;
  logic [31:0] start_cycle;
  logic        health;
  logic        alarm;

  // results still owed by the block, oldest first
  result_t owed_results[$];
  int      errors;

  assign fail_count = errors;

  // advance the predicted state by one poll and build the result it produces
  function automatic result_t poll_response(logic en, logic hb, logic [31:0] now,
                                            logic ins);
    result_t     r;
    logic [2:0]  next_code;
    logic [31:0] elapsed;
    r = '0;
    r.payload_cmd    = CMD_NONE;
    r.main_power_cmd = CMD_NONE;
    r.mgmt_power_cmd = CMD_NONE;
    next_code = fru_code;
    case (fru_code)
      CODE_INACTIVE: begin
        health = 1'b0;
        alarm  = 1'b1;
        r.alarm_raised     = 1'b1;
        r.clear_activation = 1'b1;
        r.payload_cmd      = CMD_OFF;
        r.main_power_cmd   = CMD_OFF;
        r.mgmt_power_cmd   = CMD_OFF;
        if (ins) next_code = CODE_POWERED;
      end
      CODE_POWERED: begin
        if (!en) begin
          health = 1'b0;
          alarm  = 1'b1;
          r.alarm_raised   = 1'b1;
          r.main_power_cmd = CMD_ON;
          r.payload_cmd    = CMD_OFF;
        end else begin
          r.mgmt_power_cmd = CMD_ON;
          r.main_power_cmd = CMD_ON;
          r.payload_cmd    = CMD_ON;
          start_cycle = now;
          next_code   = CODE_ACTIVATING;
        end
      end
      CODE_ACTIVATING: begin
        if (!en) begin
          r.payload_cmd = CMD_OFF;
          next_code     = CODE_DEACTIVATING;
        end else begin
          if (hb) begin
            health    = 1'b1;
            alarm     = 1'b0;
            next_code = CODE_ACTIVE;
          end
          // wrapping elapsed count; a timeout overrides the heartbeat bits
          elapsed = now - start_cycle;
          if (elapsed > timeout_q) begin
            health = 1'b0;
            alarm  = 1'b1;
            r.alarm_raised = 1'b1;
          end
        end
      end
      CODE_ACTIVE: begin
        if (!en) begin
          r.payload_cmd = CMD_OFF;
          next_code     = CODE_DEACTIVATING;
        end else begin
          health = 1'b1;
          alarm  = 1'b0;
        end
      end
      CODE_DEACTIVATING: begin
        health = 1'b0;
        alarm  = 1'b1;
        r.alarm_raised = 1'b1;
        if (!en) begin
          next_code = CODE_POWERED;
        end else begin
          start_cycle = now;
          next_code   = CODE_ACTIVATING;
        end
      end
      default: ;
    endcase
    fru_code      = next_code;
    r.state_code  = fru_code;
    r.cpu_healthy = health;
    r.other_alarm = alarm;
    return r;
  endfunction

  // report one field that differs
  task automatic check_field(string name, logic [31:0] want, logic [31:0] seen);
    if (seen !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
      errors++;
    end
  endtask

  // follow every transfer on the three channels
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      timeout_q   = TIMEOUT_RESET;
      fru_code    = CODE_INACTIVE;
      start_cycle = '0;
      health      = 1'b0;
      alarm       = 1'b0;
      owed_results.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) timeout_q = cfg_ch.data;

      // result transfer against the oldest owed result
      if (out_ch.valid && out_ch.ready) begin
        if (owed_results.size() == 0) begin
          $display("%0t: result with none expected, actual state %0d", $time,
                   out_ch.state_code);
          errors++;
        end else begin
          want = owed_results.pop_front();
          check_field("state_code", 32'(want.state_code), 32'(out_ch.state_code));
          check_field("cpu_healthy", 32'(want.cpu_healthy), 32'(out_ch.cpu_healthy));
          check_field("other_alarm", 32'(want.other_alarm), 32'(out_ch.other_alarm));
          check_field("alarm_raised", 32'(want.alarm_raised),
                      32'(out_ch.alarm_raised));
          check_field("payload_cmd", 32'(want.payload_cmd), 32'(out_ch.payload_cmd));
          check_field("main_power_cmd", 32'(want.main_power_cmd),
                      32'(out_ch.main_power_cmd));
          check_field("mgmt_power_cmd", 32'(want.mgmt_power_cmd),
                      32'(out_ch.mgmt_power_cmd));
          check_field("clear_activation", 32'(want.clear_activation),
                      32'(out_ch.clear_activation));
        end
      end

      // poll transfer
      if (in_ch.valid && in_ch.ready)
        owed_results.push_back(poll_response(in_ch.activation_enable, in_ch.heartbeat,
                                             in_ch.now_cycle, in_ch.insertion));
    end
    pending <= owed_results.size();
  end

endmodule

### tb/sv/fru_activation_state_machine_top_tb.sv
`timescale 1ns / 100ps
// stimulus and verdict for the fru activation state machine top level
// depends on fru_asm_pkg, fru_asm_if.sv, the block and fru_asm_poll_checker
module fru_activation_state_machine_top_tb;
  import fru_asm_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  fru_asm_in_if  in_ch();
  fru_asm_out_if out_ch();
  fru_asm_cfg_if cfg_ch();

  int          pending;
  int          fail_count;
  int          cycles = 0;
  logic        steady = 1'b0;
  logic [31:0] now_count = '0;

  fru_activation_state_machine_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  fru_asm_poll_checker u_poll_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .pending    (pending),
    .fail_count (fail_count)
  );

  always #5 clk = ~clk;

  // result side stalls at random, about 20 percent of the time, unless running steady
  initial out_ch.ready = 1'b0;
  always @(posedge clk) begin
    out_ch.ready <= steady || ($urandom_range(0, 99) >= 20);
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("fru_activation_state_machine_top_tb: done, errors");
      $finish;
    end
  end

  // one poll transfer, with a random gap ahead of it
  task automatic send_poll(logic en, logic hb, logic [31:0] now, logic ins);
    if (!steady && $urandom_range(0, 99) < 20) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 20);
    end
    in_ch.valid             <= 1'b1;
    in_ch.activation_enable <= en;
    in_ch.heartbeat         <= hb;
    in_ch.now_cycle         <= now;
    in_ch.insertion         <= ins;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // hold off polls until every owed result has been taken
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // timeout register write, only while idle
  task automatic write_timeout(logic [31:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // random polls; the cycle count mostly creeps forward by up to reach
  task automatic run_random(int count, logic [31:0] reach);
    int pick;
    repeat (count) begin
      pick = $urandom_range(0, 19);
      if (pick == 0)
        now_count = $urandom;
      else if (pick > 2)
        now_count += $urandom_range(0, reach);
      send_poll($urandom_range(0, 99) < 85, $urandom_range(0, 99) < 30, now_count,
                1'($urandom_range(0, 1)));
    end
    wait_drained();
  endtask

  initial begin
    in_ch.valid             = 1'b0;
    in_ch.activation_enable = 1'b0;
    in_ch.heartbeat         = 1'b0;
    in_ch.now_cycle         = '0;
    in_ch.insertion         = 1'b0;
    cfg_ch.valid            = 1'b0;
    cfg_ch.data             = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // walk every transition with the reset timeout
    send_poll(1'b0, 1'b0, 32'h0000_0000, 1'b0);  // inactive holds
    send_poll(1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1);  // insertion to powered
    send_poll(1'b0, 1'b1, 32'h0000_0010, 1'b0);  // powered, not enabled
    send_poll(1'b1, 1'b0, 32'hFFFF_FFF0, 1'b1);  // insertion ignored, activating
    send_poll(1'b1, 1'b0, 32'h0000_1760, 1'b0);  // elapsed equals timeout across wrap
    send_poll(1'b1, 1'b0, 32'h0000_1761, 1'b0);  // one past, timeout
    send_poll(1'b1, 1'b1, 32'h0000_1761, 1'b0);  // heartbeat and timeout together
    send_poll(1'b1, 1'b0, 32'h0000_2000, 1'b1);  // active holds
    send_poll(1'b0, 1'b0, 32'h0000_2001, 1'b0);  // active to deactivating
    send_poll(1'b1, 1'b0, 32'h0000_0064, 1'b0);  // deactivating back to activating
    send_poll(1'b1, 1'b1, 32'h0000_0064, 1'b0);  // heartbeat at zero elapsed
    send_poll(1'b0, 1'b1, 32'h8000_0000, 1'b1);  // active to deactivating
    send_poll(1'b0, 1'b0, 32'h8000_0001, 1'b0);  // deactivating to powered
    send_poll(1'b1, 1'b0, 32'h0000_0005, 1'b0);  // powered to activating
    send_poll(1'b0, 1'b1, 32'h0000_0006, 1'b0);  // activating to deactivating
    send_poll(1'b0, 1'b0, 32'h0000_0007, 1'b0);  // back to powered
    wait_drained();

    // zero timeout: any nonzero elapsed count times out
    write_timeout(32'd0);
    send_poll(1'b1, 1'b0, 32'h0000_0007, 1'b0);
    send_poll(1'b1, 1'b0, 32'h0000_0007, 1'b0);
    send_poll(1'b1, 1'b0, 32'h0000_0008, 1'b0);
    wait_drained();

    // largest timeout never expires
    write_timeout(32'hFFFF_FFFF);
    send_poll(1'b1, 1'b0, 32'h0000_0006, 1'b0);
    send_poll(1'b1, 1'b1, 32'h0000_0007, 1'b0);
    now_count = 32'h0000_0007;

    // random phases over several timeout settings
    wait_drained();
    write_timeout(TIMEOUT_RESET);
    run_random(110, 32'd2000);
    write_timeout(32'd0);
    run_random(110, 32'd3);
    steady = 1'b1;
    write_timeout(32'hFFFF_FFFF);
    run_random(110, 32'hFFFF_FFFF);
    steady = 1'b0;
    write_timeout($urandom_range(1, 100));
    run_random(110, 32'd40);
    write_timeout($urandom);
    run_random(110, $urandom);

    repeat (5) @(posedge clk);
    if (fail_count == 0)
      $display("fru_activation_state_machine_top_tb: done, clean");
    else
      $display("fru_activation_state_machine_top_tb: done, errors");
    $finish;
  end

endmodule

### fru_activation_state_machine_top.f
rtl/fru_asm_pkg.sv
rtl/fru_asm_if.sv
rtl/fru_activation_state_machine_top.sv
rtl/fru_asm_checker.sv
tb/sv/fru_asm_poll_checker.sv
tb/sv/fru_activation_state_machine_top_tb.sv
